FILE: sv/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the trapezoid stepper profile
// Holds the fixed-point layout, register map codes and the register struct.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned PosBits     = 32;
  localparam int unsigned VelFrac     = 8;
  localparam int unsigned PeriodBits  = 16;
  localparam int unsigned VelW        = 36;  // signed velocity word, headroom for ramps
  localparam int unsigned DivW        = 36;  // shared divider operand width
  localparam int unsigned SqrtW       = 64;  // radicand width
  localparam int unsigned AddrW       = 5;
  localparam int unsigned BrakeShift  = 2 * VelFrac + 1;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] RegStartSpeed = 3'd0;
  localparam logic [2:0] RegDefSpeed   = 3'd1;
  localparam logic [2:0] RegDefAccel   = 3'd2;
  localparam logic [2:0] RegMinPos     = 3'd3;
  localparam logic [2:0] RegMaxPos     = 3'd4;
  localparam logic [2:0] RegBaseFreq   = 3'd5;
  localparam logic [2:0] RegUpdateHz   = 3'd6;
  localparam logic [2:0] RegReverse    = 3'd7;

  // Request kinds.
  localparam logic [1:0] ReqMove = 2'd0;
  localparam logic [1:0] ReqTick = 2'd1;
  localparam logic [1:0] ReqStep = 2'd2;

  // Motion phases.
  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhAccel  = 2'd1;
  localparam logic [1:0] PhDecel  = 2'd2;
  localparam logic [1:0] PhCruise = 2'd3;

  typedef struct packed {
    logic [17:0]        start_speed;
    logic [17:0]        default_speed;
    logic [23:0]        default_accel;
    logic signed [31:0] min_position;
    logic signed [31:0] max_position;
    logic [26:0]        base_freq;
    logic [16:0]        update_hz;
    logic               reverse_dir;
  } cfg_t;

endpackage

FILE: sv/stp_if.sv
// ----------------------------------------------------------------------------
// stp_if: request and response channels of the trapezoid stepper profile
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface stp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] goal_position;
  logic [17:0]        move_speed;
  logic [23:0]        move_accel;

  modport source (output valid, req_type, goal_position, move_speed, move_accel,
                  input ready);
  modport sink (input valid, req_type, goal_position, move_speed, move_accel,
                output ready);
endinterface

interface stp_rsp_if;
  logic               valid;
  logic               ready;
  logic [15:0]        timer_period;
  logic               period_valid;
  logic               pulses_on;
  logic               dir_pin;
  logic [1:0]         motion_phase;
  logic signed [31:0] position_now;
  logic               arrived;

  modport source (output valid, timer_period, period_valid, pulses_on, dir_pin,
                  motion_phase, position_now, arrived, input ready);
  modport sink (input valid, timer_period, period_valid, pulses_on, dir_pin,
                motion_phase, position_now, arrived, output ready);
endinterface

FILE: sv/stp_cfg.sv
// ----------------------------------------------------------------------------
// stp_cfg: register file of the trapezoid stepper profile
// APB-style write and read access to the eight configuration registers.
// ----------------------------------------------------------------------------
module stp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stp_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output stp_pkg::cfg_t               cfg_o
);
  import stp_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_speed   <= 18'd100;
      cfg_q.default_speed <= 18'd1000;
      cfg_q.default_accel <= 24'd2000;
      cfg_q.min_position  <= 32'sd0;
      cfg_q.max_position  <= 32'sh7FFF_FFFF;
      cfg_q.base_freq     <= 27'd1000000;
      cfg_q.update_hz     <= 17'd1000;
      cfg_q.reverse_dir   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        RegStartSpeed: cfg_q.start_speed   <= pwdata[17:0];
        RegDefSpeed:   cfg_q.default_speed <= pwdata[17:0];
        RegDefAccel:   cfg_q.default_accel <= pwdata[23:0];
        RegMinPos:     cfg_q.min_position  <= pwdata;
        RegMaxPos:     cfg_q.max_position  <= pwdata;
        RegBaseFreq:   cfg_q.base_freq     <= pwdata[26:0];
        RegUpdateHz:   cfg_q.update_hz     <= pwdata[16:0];
        RegReverse:    cfg_q.reverse_dir   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegStartSpeed: prdata = 32'(cfg_q.start_speed);
      RegDefSpeed:   prdata = 32'(cfg_q.default_speed);
      RegDefAccel:   prdata = 32'(cfg_q.default_accel);
      RegMinPos:     prdata = cfg_q.min_position;
      RegMaxPos:     prdata = cfg_q.max_position;
      RegBaseFreq:   prdata = 32'(cfg_q.base_freq);
      RegUpdateHz:   prdata = 32'(cfg_q.update_hz);
      RegReverse:    prdata = 32'(cfg_q.reverse_dir);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: sv/stp_div.sv
// ----------------------------------------------------------------------------
// stp_div: shared restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module stp_div #(
  parameter int unsigned W = stp_pkg::DivW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      rem_sh, rem_sub;
  logic            take;

  assign rem_sh  = {rem_q, quo_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign take    = !rem_sub[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_q <= {quo_q[W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/stp_sqrt.sv
// ----------------------------------------------------------------------------
// stp_sqrt: iterative integer square root
// Digit-by-digit method, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
module stp_sqrt #(
  parameter int unsigned W = stp_pkg::SqrtW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   radicand_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  logic [W-1:0] x_q, r_q, bit_q, trial;
  logic         busy_q, done_q, fits;

  assign trial = r_q + bit_q;
  assign fits  = x_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (fits) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[W/2-1:0];

endmodule

FILE: sv/stepper_trapezoid_profile.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile: trapezoidal step-rate generator
// Work per item: step events and idle ticks need no arithmetic unit; a ramp
// tick runs two divisions; a cruise tick runs the multiplier for the braking
// distance, a braking division if needed and a period division; a move command
// runs one square root plus one division. One item is in work at a time, so a
// new request is accepted only once the sequencer is back in idle.
// Reset: asynchronous, active low; clears motion state and loads register
// defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  stp_req_if.sink                   req_i,
  stp_rsp_if.source                 rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import stp_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_M_MUL1  = 4'd2;
  localparam logic [3:0] S_M_MUL2  = 4'd3;
  localparam logic [3:0] S_M_MUL3  = 4'd4;
  localparam logic [3:0] S_M_SQRT  = 4'd5;
  localparam logic [3:0] S_T_DELTA = 4'd6;
  localparam logic [3:0] S_T_MUL1  = 4'd7;
  localparam logic [3:0] S_T_MUL2  = 4'd8;
  localparam logic [3:0] S_T_MUL3  = 4'd9;
  localparam logic [3:0] S_T_BRAKE = 4'd10;
  localparam logic [3:0] S_PER     = 4'd11;
  localparam logic [3:0] S_PER_W   = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  typedef logic signed [VelW-1:0] vel_t;

  cfg_t cfg;

  stp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Sequencer and motion state.
  logic [3:0]         st_q, st_d;
  logic signed [31:0] pos_q, pos_d, tgt_q, tgt_d;
  vel_t               vel_q, vel_d, vgoal_q, vgoal_d;
  logic [23:0]        acc_q, acc_d;
  logic [1:0]         ph_q, ph_d;
  logic               fwd_q, fwd_d, run_q, run_d;

  // Latched request and working registers.
  logic [1:0]         rt_q;
  logic signed [31:0] goal_in_q;
  logic [17:0]        spd_in_q, spd_q, spd_d;
  logic [23:0]        acc_in_q;
  logic [63:0]        prod_q, sum_q, sum_d;

  // Result staging.
  logic [PeriodBits-1:0] rper_q, rper_d;
  logic                  rval_q, rval_d, rarr_q, rarr_d;

  // Output register.
  logic                  ov_q;
  logic [15:0]           o_per_q;
  logic                  o_pv_q, o_on_q, o_dir_q, o_arr_q;
  logic [1:0]            o_ph_q;
  logic signed [31:0]    o_pos_q;

  // The shared 32x32 multiplier; its operands are chosen by the state.
  logic [31:0] mul_a, mul_b;

  // Shared divider and the square root unit.
  logic            div_start, div_done;
  logic [DivW-1:0] div_num, div_den, div_q;
  logic            sq_start, sq_done;
  logic [SqrtW-1:0]   sq_rad;
  logic [SqrtW/2-1:0] sq_root;

  stp_div #(.W(DivW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  stp_sqrt #(.W(SqrtW)) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .radicand_i(sq_rad),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

  // Derived values used by several states.
  logic signed [32:0] pdiff;
  logic [31:0]        span;
  vel_t               s_fix, g_fix, vmag, gmag, vsum, vdif, delta;
  logic signed [31:0] goal_cl;
  logic [17:0]        spd_fin;
  logic [23:0]        acc_div;
  logic [16:0]        hz_div;
  logic [63:0]        brake_num;
  logic [PeriodBits-1:0] per_sat;

  assign pdiff = 33'(tgt_q) - 33'(pos_q);
  assign span  = pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
  assign s_fix = vel_t'(cfg.start_speed) <<< VelFrac;
  assign vmag  = vel_q[VelW-1] ? -vel_q : vel_q;
  assign gmag  = vgoal_q[VelW-1] ? -vgoal_q : vgoal_q;
  assign delta = vel_t'(div_q);
  assign vsum  = vel_q + delta;
  assign vdif  = vel_q - delta;
  assign acc_div = (acc_q == 24'd0) ? 24'd1 : acc_q;
  assign hz_div  = (cfg.update_hz == 17'd0) ? 17'd1 : cfg.update_hz;
  assign brake_num = (sum_q - prod_q) >> BrakeShift;
  assign per_sat = (div_q > DivW'({PeriodBits{1'b1}})) ? {PeriodBits{1'b1}}
                                                        : div_q[PeriodBits-1:0];
  assign spd_fin = (sq_root < 32'(spd_q)) ? sq_root[17:0] : spd_q;
  assign g_fix   = vel_t'(spd_fin) <<< VelFrac;

  // Target clamp: the lower limit is applied last so it wins when the limits
  // cross.
  always_comb begin
    goal_cl = goal_in_q;
    if (goal_cl > cfg.max_position) goal_cl = cfg.max_position;
    if (goal_cl < cfg.min_position) goal_cl = cfg.min_position;
  end

  always_comb begin
    mul_a = 32'(span);
    mul_b = 32'(acc_q);
    case (st_q)
      S_M_MUL2: begin
        mul_a = 32'(cfg.start_speed);
        mul_b = 32'(cfg.start_speed);
      end
      S_T_MUL1: begin
        mul_a = gmag[31:0];
        mul_b = gmag[31:0];
      end
      S_T_MUL2: begin
        mul_a = s_fix[31:0];
        mul_b = s_fix[31:0];
      end
      default: ;
    endcase
  end

  assign sq_rad = sum_q + prod_q;

  always_comb begin
    div_num = DivW'(cfg.base_freq) << VelFrac;
    div_den = DivW'(vmag);
    case (st_q)
      S_DEC: begin
        div_num = DivW'(acc_q) << VelFrac;
        div_den = DivW'(hz_div);
      end
      S_T_MUL3: begin
        div_num = brake_num[DivW-1:0];
        div_den = DivW'(acc_div);
      end
      default: ;
    endcase
  end

  assign req_i.ready = (st_q == S_IDLE);

  // Main sequencer.
  always_comb begin
    st_d    = st_q;
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    vel_d   = vel_q;
    vgoal_d = vgoal_q;
    acc_d   = acc_q;
    ph_d    = ph_q;
    fwd_d   = fwd_q;
    run_d   = run_q;
    spd_d   = spd_q;
    sum_d   = sum_q;
    rper_d  = rper_q;
    rval_d  = rval_q;
    rarr_d  = rarr_q;
    div_start = 1'b0;
    sq_start  = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (req_i.valid) begin
          st_d   = S_DEC;
          rper_d = '0;
          rval_d = 1'b0;
          rarr_d = 1'b0;
        end
      end

      S_DEC: begin
        case (rt_q)
          ReqMove: begin
            if (goal_cl == tgt_q) begin
              st_d = S_OUT;
            end else begin
              tgt_d = goal_cl;
              acc_d = (acc_in_q == 24'd0) ? cfg.default_accel : acc_in_q;
              spd_d = (spd_in_q == 18'd0) ? cfg.default_speed : spd_in_q;
              st_d  = S_M_MUL1;
            end
          end
          ReqTick: begin
            case (ph_q)
              PhIdle: begin
                vel_d = '0;
                st_d  = S_OUT;
              end
              PhCruise: begin
                vel_d = vgoal_q;
                st_d  = S_T_MUL1;
              end
              default: begin
                // Ramp step: velocity change per tick is accel / update_hz.
                div_start = 1'b1;
                st_d      = S_T_DELTA;
              end
            endcase
          end
          ReqStep: begin
            if (run_q) begin
              pos_d = fwd_q ? pos_q + 32'sd1 : pos_q - 32'sd1;
              if (pos_d == tgt_q) begin
                run_d   = 1'b0;
                vel_d   = '0;
                vgoal_d = '0;
                ph_d    = PhIdle;
                rarr_d  = 1'b1;
              end
            end
            st_d = S_OUT;
          end
          default: st_d = S_OUT;
        endcase
      end

      // Cruise cap: sqrt(span * accel + start^2).
      S_M_MUL1: st_d = S_M_MUL2;
      S_M_MUL2: begin
        sum_d = prod_q;
        st_d  = S_M_MUL3;
      end
      S_M_MUL3: begin
        sq_start = 1'b1;
        st_d     = S_M_SQRT;
      end
      S_M_SQRT: begin
        if (sq_done) begin
          vgoal_d = (pos_q < tgt_q) ? g_fix : -g_fix;
          if (pos_q < tgt_q) begin
            if (!vel_q[VelW-1] && vel_q < g_fix) vel_d = s_fix;
            ph_d  = PhAccel;
            fwd_d = 1'b1;
            run_d = 1'b1;
            st_d  = S_PER;
          end else if (pos_q > tgt_q) begin
            if ((vel_q[VelW-1] || vel_q == '0) && vel_q > -g_fix) vel_d = -s_fix;
            ph_d  = PhDecel;
            fwd_d = 1'b0;
            run_d = 1'b1;
            st_d  = S_PER;
          end else begin
            // New target sits at the current position: nothing starts.
            st_d = S_OUT;
          end
        end
      end

      S_T_DELTA: begin
        if (div_done) begin
          if (ph_q == PhAccel) begin
            if (vsum > vgoal_q) begin
              vel_d = vgoal_q;
              ph_d  = PhCruise;
            end else begin
              vel_d = vsum;
            end
          end else begin
            if (vdif < vgoal_q) begin
              vel_d = vgoal_q;
              ph_d  = PhCruise;
            end else begin
              vel_d = vdif;
            end
          end
          st_d = S_PER;
        end
      end

      // Braking distance: (goal^2 - start^2) / (accel * 2^(2F+1)).
      S_T_MUL1: st_d = S_T_MUL2;
      S_T_MUL2: begin
        sum_d = prod_q;
        st_d  = S_T_MUL3;
      end
      S_T_MUL3: begin
        if (sum_q >= prod_q) begin
          div_start = 1'b1;
          st_d      = S_T_BRAKE;
        end else begin
          st_d = S_PER;
        end
      end
      S_T_BRAKE: begin
        if (div_done) begin
          if (DivW'(span) <= div_q) begin
            vgoal_d = (vel_q > vel_t'(0)) ? s_fix : -s_fix;
            if (vgoal_d > vel_q) ph_d = PhAccel;
            else if (vgoal_d < vel_q) ph_d = PhDecel;
          end
          st_d = S_PER;
        end
      end

      S_PER: begin
        rval_d = 1'b1;
        if (vel_q == '0) begin
          rper_d = {PeriodBits{1'b1}};
          st_d   = S_OUT;
        end else begin
          div_start = 1'b1;
          st_d      = S_PER_W;
        end
      end
      S_PER_W: begin
        if (div_done) begin
          rper_d = per_sat;
          st_d   = S_OUT;
        end
      end

      S_OUT: begin
        if (!ov_q || rsp_o.ready) st_d = S_IDLE;
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      pos_q   <= '0;
      tgt_q   <= '0;
      vel_q   <= '0;
      vgoal_q <= '0;
      acc_q   <= 24'd2000;
      ph_q    <= PhIdle;
      fwd_q   <= 1'b0;
      run_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      vel_q   <= vel_d;
      vgoal_q <= vgoal_d;
      acc_q   <= acc_d;
      ph_q    <= ph_d;
      fwd_q   <= fwd_d;
      run_q   <= run_d;
      if (st_q == S_OUT && (!ov_q || rsp_o.ready)) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      rt_q      <= req_i.req_type;
      goal_in_q <= req_i.goal_position;
      spd_in_q  <= req_i.move_speed;
      acc_in_q  <= req_i.move_accel;
    end
    spd_q  <= spd_d;
    sum_q  <= sum_d;
    prod_q <= 64'(mul_a) * 64'(mul_b);
    rper_q <= rper_d;
    rval_q <= rval_d;
    rarr_q <= rarr_d;
    if (st_q == S_OUT && (!ov_q || rsp_o.ready)) begin
      o_per_q <= rper_q[15:0];
      o_pv_q  <= rval_q;
      o_on_q  <= run_q;
      o_dir_q <= fwd_q ^ cfg.reverse_dir;
      o_ph_q  <= ph_q;
      o_pos_q <= pos_q;
      o_arr_q <= rarr_q;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.timer_period = o_per_q;
  assign rsp_o.period_valid = o_pv_q;
  assign rsp_o.pulses_on    = o_on_q;
  assign rsp_o.dir_pin      = o_dir_q;
  assign rsp_o.motion_phase = o_ph_q;
  assign rsp_o.position_now = o_pos_q;
  assign rsp_o.arrived      = o_arr_q;

  // An accepted transaction always moves the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> st_q != S_IDLE)
    else $error("sequencer stayed idle after an accepted request");

  // The divider is only started when the next state waits for its result.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (st_q == S_T_DELTA || st_q == S_T_BRAKE || st_q == S_PER_W))
    else $error("divider started without a waiting state");

  // Pulses only start at the end of a move's square root.
  a_run_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_q) |-> $past(st_q) == S_M_SQRT)
    else $error("pulses started outside a move");

  // Reaching the target stops pulse generation in the same response.
  a_arrive_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) && o_arr_q |-> !o_on_q && o_ph_q == PhIdle)
    else $error("arrival reported while still running");

endmodule
